[hw/rtl/ntp_pkg.sv]
// Shared package for the two-nearest-point ratio search core.
// Holds the output field widths, register indexes, status codes and the pipe control struct.
// No dependencies.
package ntp_pkg;

  // Result field widths (fixed by the result format, not by the core parameters)
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_INDEX_W = 20;
  localparam int unsigned OUT_DIST_W  = 50;
  localparam int unsigned OUT_W       = STATUS_W + 2 * OUT_INDEX_W + 1 + 2 * OUT_DIST_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_W;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_X = 2'd0,
    REG_QUERY_Y = 2'd1,
    REG_QUERY_Z = 2'd2
  } ntp_reg_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_UNIQUE    = 2'd0,
    ST_AMBIGUOUS = 2'd1,
    ST_EMPTY     = 2'd2
  } ntp_status_e;

  // Saturating candidate count codes
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  // Control handed to the running top-two cell
  typedef struct packed {
    logic en;     // pipeline advances this cycle
    logic valid;  // a candidate sits in the distance stage
    logic last;   // that candidate closes the search
  } ntp_ctl_t;

endpackage

[hw/rtl/ntp_axis_cell.sv]
// One axis lane: difference, then magnitude squared, two registered steps.
// Depends on nothing but its parameters.
module ntp_axis_cell #(
  parameter int unsigned COORD_W = 24
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [COORD_W-1:0] query_i,
  input  logic signed [COORD_W-1:0] cand_i,
  output logic [2*COORD_W+1:0]      sq_o
);
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned SQ_W   = 2 * COORD_W + 2;

  logic signed [DIFF_W-1:0] diff_d, diff_q;
  logic        [DIFF_W-1:0] mag;
  logic        [SQ_W-1:0]   sq_d, sq_q;

  assign diff_d = DIFF_W'(cand_i) - DIFF_W'(query_i);

  // |diff| fits DIFF_W bits unsigned, including the most negative case
  assign mag  = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
  assign sq_d = SQ_W'(mag) * SQ_W'(mag);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= diff_d;
      sq_q   <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

[hw/rtl/ntp_top2_cell.sv]
// Running nearest / next-nearest tracker with a snapshot register for the closing candidate.
// Depends on ntp_pkg.
module ntp_top2_cell #(
  parameter int unsigned DIST_W  = 50,
  parameter int unsigned LABEL_W = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ntp_pkg::ntp_ctl_t   ctl_i,
  input  logic [DIST_W-1:0]   dist_i,
  input  logic [LABEL_W-1:0]  label_i,
  output logic                snap_valid_o,
  output logic [DIST_W-1:0]   snap_best_dist_o,
  output logic [DIST_W-1:0]   snap_run_dist_o,
  output logic [LABEL_W-1:0]  snap_best_label_o,
  output logic [LABEL_W-1:0]  snap_run_label_o,
  output logic [1:0]          snap_seen_o
);
  import ntp_pkg::*;

  logic [DIST_W-1:0]  best_q, run_q, best_d, run_d;
  logic [LABEL_W-1:0] best_lbl_q, run_lbl_q, best_lbl_d, run_lbl_d;
  logic [1:0]         seen_q, seen_d;
  logic               lt_best, lt_run, take;

  logic               snap_valid_q;
  logic [DIST_W-1:0]  snap_best_q, snap_run_q;
  logic [LABEL_W-1:0] snap_best_lbl_q, snap_run_lbl_q;
  logic [1:0]         snap_seen_q;

  // strict less-than: the earlier of two equal distances keeps its place
  assign lt_best = dist_i < best_q;
  assign lt_run  = dist_i < run_q;
  assign take    = ctl_i.en && ctl_i.valid;

  always_comb begin
    best_d     = best_q;
    best_lbl_d = best_lbl_q;
    run_d      = run_q;
    run_lbl_d  = run_lbl_q;
    if (lt_best) begin
      run_d      = best_q;
      run_lbl_d  = best_lbl_q;
      best_d     = dist_i;
      best_lbl_d = label_i;
    end else if (lt_run) begin
      run_d     = dist_i;
      run_lbl_d = label_i;
    end
    seen_d = (seen_q == SEEN_TWO) ? SEEN_TWO : 2'(seen_q + 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q     <= '1;
      run_q      <= '1;
      best_lbl_q <= '0;
      run_lbl_q  <= '0;
      seen_q     <= SEEN_NONE;
    end else if (take) begin
      if (ctl_i.last) begin
        best_q     <= '1;
        run_q      <= '1;
        best_lbl_q <= '0;
        run_lbl_q  <= '0;
        seen_q     <= SEEN_NONE;
      end else begin
        best_q     <= best_d;
        run_q      <= run_d;
        best_lbl_q <= best_lbl_d;
        run_lbl_q  <= run_lbl_d;
        seen_q     <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      snap_valid_q <= ctl_i.valid && ctl_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && ctl_i.last) begin
      snap_best_q     <= best_d;
      snap_run_q      <= run_d;
      snap_best_lbl_q <= best_lbl_d;
      snap_run_lbl_q  <= run_lbl_d;
      snap_seen_q     <= seen_d;
    end
  end

  assign snap_valid_o      = snap_valid_q;
  assign snap_best_dist_o  = snap_best_q;
  assign snap_run_dist_o   = snap_run_q;
  assign snap_best_label_o = snap_best_lbl_q;
  assign snap_run_label_o  = snap_run_lbl_q;
  assign snap_seen_o       = snap_seen_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && ctl_i.last |=> seen_q == SEEN_NONE && best_q == '1)
    else $error("run state not cleared after closing candidate");

  assert property (@(posedge clk_i) disable iff (!rst_ni) best_q <= run_q)
    else $error("nearest distance above next-nearest");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_q |-> snap_seen_q != SEEN_NONE)
    else $error("snapshot taken with no candidate counted");

endmodule

[hw/rtl/ntp_out_skid.sv]
// Output register plus one skid entry; the upstream side stalls only when the skid is full.
// Depends on nothing but its parameters.
module ntp_out_skid #(
  parameter int unsigned DATA_W = 144
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o
);
  logic              out_v_q, skid_v_q;
  logic [DATA_W-1:0] out_data_q, skid_data_q;
  logic              push, pop;

  assign in_ready_o = !skid_v_q;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = out_v_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || pop) begin
        if (skid_v_q) begin
          out_v_q  <= 1'b1;
          skid_v_q <= 1'b0;
        end else begin
          out_v_q <= push;
        end
      end else if (push) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      if (skid_v_q) begin
        out_data_q <= skid_data_q;
      end else if (push) begin
        out_data_q <= in_data_i;
      end
    end else if (push) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_v_q |-> out_v_q)
    else $error("skid entry held while output register empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_ready_i |=> skid_v_q && $stable(skid_data_q))
    else $error("skid entry lost or changed while output stalled");

endmodule

[hw/rtl/nearest_two_point_ratio_search_core.sv]
// Two-nearest-point search with ratio test. Throughput: one candidate per cycle while the
// skid entry is empty. A closing candidate's result reaches m_axis through the stages
// difference, square, sum, top-two update + snapshot, status/output register.
// Output is an output register plus one skid entry; input stalls only when both hold results.
// Reset (rst_ni, async, active low): query registers to 0, run state to empty, no result pending.
// Depends on ntp_pkg, ntp_axis_cell, ntp_top2_cell, ntp_out_skid.
module nearest_two_point_ratio_search_core #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned INDEX_BITS = 20,
  localparam int unsigned IN_W      = 3 * COORD_BITS + INDEX_BITS,
  localparam int unsigned S_TDATA_W = ((IN_W + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ntp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [COORD_BITS-1:0]             cfg_data_i,
  // candidate stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata, low to high: cand_x, cand_y, cand_z, cand_index, zero pad
  input  logic [S_TDATA_W-1:0]              s_axis_tdata_i,
  input  logic                              s_axis_tlast_i,   // last_cand
  // result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata, low to high: status, nearest_index, second_index, second_present,
  // nearest_dist_sq, second_dist_sq, zero pad
  output logic [ntp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import ntp_pkg::*;

  localparam int unsigned DIST_W    = 2 * COORD_BITS + 2;  // holds any sum of three squares
  localparam int unsigned IDX_EXT_W = (INDEX_BITS > OUT_INDEX_W) ? INDEX_BITS : OUT_INDEX_W;
  localparam int unsigned DST_EXT_W = (DIST_W > OUT_DIST_W) ? DIST_W : OUT_DIST_W;

  // ---------------------------------------------------------------- query registers
  logic signed [COORD_BITS-1:0] query_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q[0] <= '0;
      query_q[1] <= '0;
      query_q[2] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_QUERY_X: query_q[0] <= cfg_data_i;
        REG_QUERY_Y: query_q[1] <= cfg_data_i;
        REG_QUERY_Z: query_q[2] <= cfg_data_i;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- pipeline control
  // Every stage moves together; the only stall comes from a full skid entry.
  logic pipe_en;
  logic v1_q, v2_q, v3_q;
  logic last1_q, last2_q, last3_q;
  logic [INDEX_BITS-1:0] label1_q, label2_q, label3_q;

  assign s_axis_tready_o = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      label1_q <= s_axis_tdata_i[3*COORD_BITS +: INDEX_BITS];
      label2_q <= label1_q;
      label3_q <= label2_q;
      last1_q  <= s_axis_tlast_i;
      last2_q  <= last1_q;
      last3_q  <= last2_q;
    end
  end

  // ---------------------------------------------------------------- axis lanes
  // Three identical cells; each registers the x, y or z difference and then its square.
  logic [DIST_W-1:0] sq [3];

  for (genvar g = 0; g < 3; g++) begin : g_axis
    ntp_axis_cell #(
      .COORD_W (COORD_BITS)
    ) u_axis (
      .clk_i   (clk_i),
      .en_i    (pipe_en),
      .query_i (query_q[g]),
      .cand_i  (s_axis_tdata_i[g*COORD_BITS +: COORD_BITS]),
      .sq_o    (sq[g])
    );
  end

  // squared distance; no overflow at DIST_W bits
  logic [DIST_W-1:0] dist3_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dist3_q <= sq[0] + sq[1] + sq[2];
    end
  end

  // ---------------------------------------------------------------- top-two tracking
  ntp_ctl_t          ctl;
  logic              snap_valid;
  logic [DIST_W-1:0] snap_best, snap_run;
  logic [INDEX_BITS-1:0] snap_best_lbl, snap_run_lbl;
  logic [1:0]        snap_seen;

  assign ctl = '{en: pipe_en, valid: v3_q, last: last3_q};

  ntp_top2_cell #(
    .DIST_W  (DIST_W),
    .LABEL_W (INDEX_BITS)
  ) u_top2 (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .dist_i            (dist3_q),
    .label_i           (label3_q),
    .snap_valid_o      (snap_valid),
    .snap_best_dist_o  (snap_best),
    .snap_run_dist_o   (snap_run),
    .snap_best_label_o (snap_best_lbl),
    .snap_run_label_o  (snap_run_lbl),
    .snap_seen_o       (snap_seen)
  );

  // ---------------------------------------------------------------- result format
  // Ratio test: runner < 4 * nearest, done as (runner >> 2) < nearest so nothing overflows.
  // A zero nearest distance never fails the test.
  logic                   two;
  logic                   too_close;
  ntp_status_e            status;
  logic [IDX_EXT_W-1:0]   best_lbl_ext, run_lbl_ext;
  logic [DST_EXT_W-1:0]   best_dst_ext, run_dst_ext;
  logic [OUT_INDEX_W-1:0] nearest_index, second_index;
  logic [OUT_DIST_W-1:0]  nearest_dist_sq, second_dist_sq;
  logic [OUT_TDATA_W-1:0] res_data;

  assign two       = (snap_seen == SEEN_TWO);
  assign too_close = (snap_run >> 2) < snap_best;

  always_comb begin
    if (snap_seen == SEEN_NONE) begin
      status = ST_EMPTY;
    end else if (two && too_close) begin
      status = ST_AMBIGUOUS;
    end else begin
      status = ST_UNIQUE;
    end
  end

  assign best_lbl_ext = IDX_EXT_W'(snap_best_lbl);
  assign run_lbl_ext  = IDX_EXT_W'(snap_run_lbl);
  assign best_dst_ext = DST_EXT_W'(snap_best);
  assign run_dst_ext  = DST_EXT_W'(snap_run);

  assign nearest_index   = best_lbl_ext[OUT_INDEX_W-1:0];
  assign second_index    = two ? run_lbl_ext[OUT_INDEX_W-1:0] : '0;
  assign nearest_dist_sq = best_dst_ext[OUT_DIST_W-1:0];
  assign second_dist_sq  = two ? run_dst_ext[OUT_DIST_W-1:0] : '1;

  assign res_data = {{OUT_PAD_W{1'b0}}, second_dist_sq, nearest_dist_sq, two,
                     second_index, nearest_index, status};

  // ---------------------------------------------------------------- output buffer
  ntp_out_skid #(
    .DATA_W (OUT_TDATA_W)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (snap_valid),
    .in_ready_o  (pipe_en),
    .in_data_i   (res_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
